// ===== rtl/core/qbf_pkg.sv =====
// ----------------------------------------------------------------------------
// qbf_pkg
// Shared types and constants for the quadratic Bezier flattener.
// ----------------------------------------------------------------------------
package qbf_pkg;

    localparam int COORD_W   = 24;   // Q12.12 coordinate
    localparam int STEP_W    = 6;    // step count field
    localparam int CFG_IDX_W = 2;    // configuration register index
    localparam int MIN_STEPS = 2;
    localparam int MAX_STEPS = 63;

    localparam int COEF_C_W  = 11;   // 2*k*(n-k) <= 1984
    localparam int COEF_E_W  = 12;   // k*k <= 3844
    localparam int SQ_W      = 12;   // n*n <= 3969
    localparam int PROD_W    = 37;   // signed numerator
    localparam int DVD_W     = 36;   // 2*|num| + n*n
    localparam int DSR_W     = 13;   // 2*n*n
    localparam int DIV_STEPS = COORD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CTRL_X = 2'd0,
        REG_CTRL_Y = 2'd1,
        REG_END_X  = 2'd2,
        REG_END_Y  = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ORIGIN,
        S_COEF,
        S_MUL,
        S_SUM,
        S_PREP,
        S_DIV,
        S_RES,
        S_EMIT,
        S_FINAL
    } state_t;

    typedef struct packed {
        logic load;       // latch step count, load origin into output regs
        logic put_end;    // load end point, flagged last
        logic put_quot;   // load divider results
        logic coef;       // register k*(n-k) and k*k
        logic mul;        // register lane products
        logic sum;        // register numerator
        logic div_start;  // load divider
        logic div_step;   // one quotient bit
        logic k_inc;      // next interior vertex
    } dp_cmd_t;

    typedef struct packed {
        logic ctrl_zero;
        logic last_interior;
    } dp_status_t;

endpackage

// ===== rtl/core/qbf_lane.sv =====
// ----------------------------------------------------------------------------
// qbf_lane
// One coordinate lane: numerator products, sum, and a restoring divider
// that produces the rounded quotient one bit per cycle.
// ----------------------------------------------------------------------------
module qbf_lane (
    input  logic                                  clk,
    input  qbf_pkg::dp_cmd_t                      cmd,
    input  logic signed [qbf_pkg::COORD_W-1:0]    c,
    input  logic signed [qbf_pkg::COORD_W-1:0]    e,
    input  logic        [qbf_pkg::COEF_C_W-1:0]   coef_c,
    input  logic        [qbf_pkg::COEF_E_W-1:0]   coef_e,
    input  logic        [qbf_pkg::SQ_W-1:0]       d,
    output logic signed [qbf_pkg::COORD_W-1:0]    result
);

    logic signed [qbf_pkg::PROD_W-1:0]   prod_c_reg;
    logic signed [qbf_pkg::PROD_W-1:0]   prod_e_reg;
    logic signed [qbf_pkg::PROD_W-1:0]   num_reg;
    logic                                neg_reg;
    logic        [qbf_pkg::DSR_W-1:0]    rem_reg;
    logic        [qbf_pkg::COORD_W-1:0]  quo_reg;

    logic signed [qbf_pkg::PROD_W-2:0]   prod_c;
    logic signed [qbf_pkg::PROD_W-1:0]   prod_e;
    logic        [qbf_pkg::PROD_W-1:0]   mag;
    logic        [qbf_pkg::DVD_W-1:0]    dvd;
    logic        [qbf_pkg::DSR_W-1:0]    dsr;
    logic        [qbf_pkg::DSR_W:0]      trial;
    logic        [qbf_pkg::DSR_W:0]      diff;
    logic                                ge;
    logic        [qbf_pkg::DSR_W-1:0]    rem_next;

    assign prod_c = (qbf_pkg::PROD_W-1)'(c)
                  * (qbf_pkg::PROD_W-1)'($signed({1'b0, coef_c}));
    assign prod_e = qbf_pkg::PROD_W'(e) * qbf_pkg::PROD_W'($signed({1'b0, coef_e}));

    // round half away from zero: floor((2|num| + d) / 2d)
    assign mag   = num_reg[qbf_pkg::PROD_W-1] ? qbf_pkg::PROD_W'(-num_reg)
                                               : qbf_pkg::PROD_W'(num_reg);
    assign dvd   = {mag[qbf_pkg::DVD_W-2:0], 1'b0} + qbf_pkg::DVD_W'(d);
    assign dsr   = {d, 1'b0};
    assign trial = {rem_reg, quo_reg[qbf_pkg::COORD_W-1]};
    assign diff  = trial - {1'b0, dsr};
    assign ge    = trial >= {1'b0, dsr};

    always_comb
    begin
        if (ge)
        begin
            rem_next = diff[qbf_pkg::DSR_W-1:0];
        end
        else
        begin
            rem_next = trial[qbf_pkg::DSR_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_c_reg <= qbf_pkg::PROD_W'(prod_c);
            prod_e_reg <= prod_e;
        end
        if (cmd.sum)
        begin
            num_reg <= prod_c_reg + prod_e_reg;
        end
        if (cmd.div_start)
        begin
            neg_reg <= num_reg[qbf_pkg::PROD_W-1];
            // quotient fits in COORD_W bits, so the upper dividend part is below 2d
            rem_reg <= qbf_pkg::DSR_W'(dvd[qbf_pkg::DVD_W-1:qbf_pkg::COORD_W]);
            quo_reg <= dvd[qbf_pkg::COORD_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[qbf_pkg::COORD_W-2:0], ge};
        end
    end

    assign result = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

// ===== rtl/core/qbf_datapath.sv =====
// ----------------------------------------------------------------------------
// qbf_datapath
// Configuration registers, step/vertex counters, coefficient stage,
// two coordinate lanes and the output registers.
// ----------------------------------------------------------------------------
module qbf_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic        [qbf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [qbf_pkg::COORD_W-1:0]    cfg_data,
    input  logic        [qbf_pkg::STEP_W-1:0]     step_count,
    input  qbf_pkg::dp_cmd_t                      cmd,
    output qbf_pkg::dp_status_t                   status,
    output logic signed [qbf_pkg::COORD_W-1:0]    point_x,
    output logic signed [qbf_pkg::COORD_W-1:0]    point_y,
    output logic                                  last_point
);

    logic signed [qbf_pkg::COORD_W-1:0]   ctrl_x_reg;
    logic signed [qbf_pkg::COORD_W-1:0]   ctrl_y_reg;
    logic signed [qbf_pkg::COORD_W-1:0]   end_x_reg;
    logic signed [qbf_pkg::COORD_W-1:0]   end_y_reg;

    logic        [qbf_pkg::STEP_W-1:0]    n_reg;
    logic        [qbf_pkg::STEP_W-1:0]    k_reg;
    logic        [qbf_pkg::SQ_W-1:0]      d_reg;
    logic        [qbf_pkg::COEF_C_W-1:0]  coef_c_reg;
    logic        [qbf_pkg::COEF_E_W-1:0]  coef_e_reg;
    logic signed [qbf_pkg::COORD_W-1:0]   point_x_reg;
    logic signed [qbf_pkg::COORD_W-1:0]   point_y_reg;
    logic                                 last_reg;

    logic        [qbf_pkg::STEP_W-1:0]    n_sat;
    logic        [qbf_pkg::SQ_W-1:0]      n_sq;
    logic        [qbf_pkg::STEP_W-1:0]    n_minus_k;
    logic        [qbf_pkg::COEF_E_W-1:0]  k_nk;
    logic        [qbf_pkg::COEF_E_W-1:0]  k_sq;
    logic signed [qbf_pkg::COORD_W-1:0]   res_x;
    logic signed [qbf_pkg::COORD_W-1:0]   res_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_x_reg <= '0;
            ctrl_y_reg <= '0;
            end_x_reg  <= '0;
            end_y_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (qbf_pkg::cfg_reg_t'(cfg_index))
                qbf_pkg::REG_CTRL_X: ctrl_x_reg <= cfg_data;
                qbf_pkg::REG_CTRL_Y: ctrl_y_reg <= cfg_data;
                qbf_pkg::REG_END_X:  end_x_reg  <= cfg_data;
                qbf_pkg::REG_END_Y:  end_y_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (step_count < qbf_pkg::STEP_W'(qbf_pkg::MIN_STEPS))
        begin
            n_sat = qbf_pkg::STEP_W'(qbf_pkg::MIN_STEPS);
        end
        else if (step_count > qbf_pkg::STEP_W'(qbf_pkg::MAX_STEPS))
        begin
            n_sat = qbf_pkg::STEP_W'(qbf_pkg::MAX_STEPS);
        end
        else
        begin
            n_sat = step_count;
        end
    end

    assign n_sq      = {6'd0, n_sat} * {6'd0, n_sat};
    assign n_minus_k = n_reg - k_reg;
    assign k_nk      = {6'd0, k_reg} * {6'd0, n_minus_k};
    assign k_sq      = {6'd0, k_reg} * {6'd0, k_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= qbf_pkg::STEP_W'(qbf_pkg::MIN_STEPS);
            k_reg <= '0;
        end
        else if (cmd.load)
        begin
            n_reg <= n_sat;
            k_reg <= qbf_pkg::STEP_W'(1);
        end
        else if (cmd.k_inc)
        begin
            k_reg <= k_reg + qbf_pkg::STEP_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            d_reg <= n_sq;
        end
        if (cmd.coef)
        begin
            coef_c_reg <= {k_nk[qbf_pkg::COEF_C_W-2:0], 1'b0};
            coef_e_reg <= k_sq;
        end
        if (cmd.load)
        begin
            point_x_reg <= '0;
            point_y_reg <= '0;
            last_reg    <= 1'b0;
        end
        else if (cmd.put_end)
        begin
            point_x_reg <= end_x_reg;
            point_y_reg <= end_y_reg;
            last_reg    <= 1'b1;
        end
        else if (cmd.put_quot)
        begin
            point_x_reg <= res_x;
            point_y_reg <= res_y;
            last_reg    <= 1'b0;
        end
    end

    qbf_lane u_lane_x (
        .clk    (clk),
        .cmd    (cmd),
        .c      (ctrl_x_reg),
        .e      (end_x_reg),
        .coef_c (coef_c_reg),
        .coef_e (coef_e_reg),
        .d      (d_reg),
        .result (res_x)
    );

    qbf_lane u_lane_y (
        .clk    (clk),
        .cmd    (cmd),
        .c      (ctrl_y_reg),
        .e      (end_y_reg),
        .coef_c (coef_c_reg),
        .coef_e (coef_e_reg),
        .d      (d_reg),
        .result (res_y)
    );

    assign status.ctrl_zero     = (ctrl_x_reg == '0) && (ctrl_y_reg == '0);
    assign status.last_interior = (k_reg == n_reg - qbf_pkg::STEP_W'(1));

    assign point_x    = point_x_reg;
    assign point_y    = point_y_reg;
    assign last_point = last_reg;

`ifndef NO_ASSERTIONS
    // interior vertex index stays strictly inside the step range
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.coef |-> (k_reg != '0) && (k_reg < n_reg))
        else $error("vertex index out of range");

    // the end point is flagged and carries the configured end coordinates
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.put_end |=> last_reg && (point_x_reg == end_x_reg)
                        && (point_y_reg == end_y_reg))
        else $error("end point not loaded");
`endif

endmodule

// ===== rtl/core/qbf_ctrl.sv =====
// ----------------------------------------------------------------------------
// qbf_ctrl
// Sequencer for one flattening run: origin, per-vertex multiply/divide
// steps, end point. Drives the datapath commands and the handshakes.
// ----------------------------------------------------------------------------
module qbf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  qbf_pkg::dp_status_t  status,
    output qbf_pkg::dp_cmd_t     cmd
);

    qbf_pkg::state_t                 state_reg;
    qbf_pkg::state_t                 state_next;
    logic [qbf_pkg::DIV_CNT_W-1:0]   div_cnt_reg;
    logic [qbf_pkg::DIV_CNT_W-1:0]   div_cnt_next;
    logic                            div_last;

    assign div_last = (div_cnt_reg == qbf_pkg::DIV_CNT_W'(qbf_pkg::DIV_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= qbf_pkg::S_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        case (state_reg)
            qbf_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = qbf_pkg::S_ORIGIN;
                end
            end
            qbf_pkg::S_ORIGIN:
            begin
                if (out_ready)
                begin
                    state_next = status.ctrl_zero ? qbf_pkg::S_FINAL : qbf_pkg::S_COEF;
                end
            end
            qbf_pkg::S_COEF: state_next = qbf_pkg::S_MUL;
            qbf_pkg::S_MUL:  state_next = qbf_pkg::S_SUM;
            qbf_pkg::S_SUM:  state_next = qbf_pkg::S_PREP;
            qbf_pkg::S_PREP: state_next = qbf_pkg::S_DIV;
            qbf_pkg::S_DIV:
            begin
                if (div_last)
                begin
                    state_next   = qbf_pkg::S_RES;
                    div_cnt_next = '0;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg + qbf_pkg::DIV_CNT_W'(1);
                end
            end
            qbf_pkg::S_RES:  state_next = qbf_pkg::S_EMIT;
            qbf_pkg::S_EMIT:
            begin
                if (out_ready)
                begin
                    state_next = status.last_interior ? qbf_pkg::S_FINAL
                                                      : qbf_pkg::S_COEF;
                end
            end
            qbf_pkg::S_FINAL:
            begin
                if (out_ready)
                begin
                    state_next = qbf_pkg::S_IDLE;
                end
            end
            default: state_next = qbf_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            qbf_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            qbf_pkg::S_ORIGIN:
            begin
                out_valid   = 1'b1;
                cmd.put_end = out_ready && status.ctrl_zero;
            end
            qbf_pkg::S_COEF: cmd.coef      = 1'b1;
            qbf_pkg::S_MUL:  cmd.mul       = 1'b1;
            qbf_pkg::S_SUM:  cmd.sum       = 1'b1;
            qbf_pkg::S_PREP: cmd.div_start = 1'b1;
            qbf_pkg::S_DIV:  cmd.div_step  = 1'b1;
            qbf_pkg::S_RES:  cmd.put_quot  = 1'b1;
            qbf_pkg::S_EMIT:
            begin
                out_valid   = 1'b1;
                cmd.put_end = out_ready && status.last_interior;
                cmd.k_inc   = out_ready && !status.last_interior;
            end
            qbf_pkg::S_FINAL: out_valid = 1'b1;
            default: ;
        endcase
    end

`ifndef NO_ASSERTIONS
    // the step counter only runs while dividing
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != qbf_pkg::S_DIV) |-> (div_cnt_reg == '0))
        else $error("divider count active outside divide");

    // the divider always completes its full set of steps
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == qbf_pkg::S_DIV) && (state_next != qbf_pkg::S_DIV) |-> div_last)
        else $error("divide left early");

    // never take a new request while a vertex is on offer
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output active together");

    // a vertex leaves the divider only after a full multiply/divide pass
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.put_quot |-> $past(cmd.div_step) && $past(div_last))
        else $error("quotient taken before divide finished");
`endif

endmodule

// ===== rtl/core/quadratic_bezier_flattener.sv =====
// ----------------------------------------------------------------------------
// quadratic_bezier_flattener
// Uniform flattening of a quadratic Bezier curve from the origin through a
// configured control point to a configured end point.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel: cfg_index selects ctrl_x, ctrl_y, end_x, end_y (0..3);
//   cfg_data is the signed Q12.12 value. Always ready; write only when idle.
//   in channel: one transaction carries step_count n (clamped to 2..63).
//   out channel: the origin, n-1 interior vertices at t = k/n, then the end
//   point with last_point set. A zero control point gives only the origin
//   and the end point.
// Timing: the origin is offered in the cycle after the request is taken. Each
//   interior vertex passes through coefficient, multiply, sum, divider load,
//   the bit-serial divider, result load and output, plus any output wait.
//   One request is in flight at a time; in_ready returns after the end point
//   is taken.
// Stall: a vertex stays on the outputs while out_ready is low; work resumes
//   once it is taken.
// Reset: all configuration registers clear to zero and the block goes idle.
// ----------------------------------------------------------------------------
module quadratic_bezier_flattener (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic        [qbf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [qbf_pkg::COORD_W-1:0]    cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic        [qbf_pkg::STEP_W-1:0]     step_count,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [qbf_pkg::COORD_W-1:0]    point_x,
    output logic signed [qbf_pkg::COORD_W-1:0]    point_y,
    output logic                                  last_point
);

    qbf_pkg::dp_cmd_t     cmd;
    qbf_pkg::dp_status_t  status;

    assign cfg_ready = 1'b1;

    qbf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    qbf_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .step_count (step_count),
        .cmd        (cmd),
        .status     (status),
        .point_x    (point_x),
        .point_y    (point_y),
        .last_point (last_point)
    );

endmodule
